@@ sv/rwcf_pkg.sv @@
// ----------------------------------------------------------------------------
// rwcf_pkg
// types and constants for the radar word checker and formatter
// ----------------------------------------------------------------------------
`default_nettype none

package rwcf_pkg;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_BAD_TAG       = 2'd1,
        ST_AZ_NOT_RISING = 2'd2,
        ST_HGT_NO_RNG    = 2'd3
    } t_status;

    localparam logic [3:0]  TAG_AZ  = 4'h8;
    localparam logic [3:0]  TAG_RNG = 4'h3;
    localparam logic [3:0]  TAG_HGT = 4'hC;

    localparam logic [15:0] AZ_MASK     = 16'h8FFF;
    localparam logic [7:0]  AZ_WRAP_HI  = 8'h8F;
    localparam logic [7:0]  AZ_WRAP_LO  = 8'h80;
    localparam logic [7:0]  PLOT_TAIL_4 = 8'h00;
    localparam logic [7:0]  PLOT_TAIL_5 = 8'hC0;
    localparam logic [7:0]  RANGE_OFFSET_RST = 8'd19;

    localparam int unsigned NUM_BYTES = 6;

    localparam logic CFG_HEADER_BYTES = 1'b0;
    localparam logic CFG_RANGE_OFFSET = 1'b1;

endpackage

`default_nettype wire

@@ sv/rwcf_word_if.sv @@
// ----------------------------------------------------------------------------
// rwcf_word_if
// radar word input channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rwcf_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_in;

    modport source (output valid, output word_in, input ready);
    modport sink   (input valid, input word_in, output ready);
endinterface

`default_nettype wire

@@ sv/rwcf_byte_if.sv @@
// ----------------------------------------------------------------------------
// rwcf_byte_if
// formatted byte output channel, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface rwcf_byte_if;
    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last_of_run;
    rwcf_pkg::t_status check_status;
    logic             flush_request;
    logic             restart_mark;

    modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                    output check_status, output flush_request, output restart_mark,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last_of_run,
                    input check_status, input flush_request, input restart_mark,
                    output ready);
endinterface

`default_nettype wire

@@ sv/radar_word_checker_formatter_unit.sv @@
// ----------------------------------------------------------------------------
// radar_word_checker_formatter_unit
// checks tagged radar words and formats sector headers and plot bytes
// ----------------------------------------------------------------------------
// a word is registered in the input stage, then loaded into the result stage, which offers its first result
// throughput: one result per cycle while the output port is ready; a word gives 1, 4 or 6
// results (one per output transaction), shifted out of the result byte shift register
// a new word is taken while the previous word's results drain
// reset: synchronous active low, clears checker state, config to defaults
`default_nettype none

module radar_word_checker_formatter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    rwcf_word_if.sink        i_word_ch,
    rwcf_byte_if.source      o_byte_ch
);

    // config
    logic [31:0] r_header_bytes;
    logic [7:0]  r_range_offset;

    // input stage
    logic        r_in_valid;
    logic [15:0] r_word;

    // checker and formatter state
    logic        r_check_started, n_check_started;
    logic [15:0] r_prev_azimuth,  n_prev_azimuth;
    logic [15:0] r_prev_word,     n_prev_word;
    logic [15:0] r_held_azimuth,  n_held_azimuth;
    logic [3:0]  r_seen_sector,   n_seen_sector;
    logic [3:0]  r_current_sector, n_current_sector;

    // result stage
    logic              r_busy;
    logic [2:0]        r_left,   n_left;
    logic              r_bv,     n_bv;
    rwcf_pkg::t_status r_status, n_status;
    logic [7:0]        r_bytes [rwcf_pkg::NUM_BYTES];
    logic [7:0]        n_bytes [rwcf_pkg::NUM_BYTES];

    logic        take;
    logic        load;
    logic [3:0]  tag;
    logic [15:0] pa_masked;
    logic        az_wrap;
    logic [14:0] rng;
    logic [3:0]  az_sect;
    logic [3:0]  held_sect;
    logic [3:0]  neighbour;

    assign take = r_busy && o_byte_ch.ready;
    assign load = r_in_valid && (!r_busy || (take && (r_left == 3'd1)));
    assign i_word_ch.ready = !r_in_valid || load;

    assign o_byte_ch.valid         = r_busy;
    assign o_byte_ch.out_byte      = r_bytes[0];
    assign o_byte_ch.byte_valid    = r_bv;
    assign o_byte_ch.last_of_run   = (r_left == 3'd1);
    assign o_byte_ch.check_status  = r_status;
    assign o_byte_ch.flush_request = (r_status != rwcf_pkg::ST_OK);
    assign o_byte_ch.restart_mark  = (r_status == rwcf_pkg::ST_HGT_NO_RNG);

    assign tag       = r_word[15:12];
    assign pa_masked = r_prev_azimuth & rwcf_pkg::AZ_MASK;
    assign az_wrap   = (pa_masked[15:8] == rwcf_pkg::AZ_WRAP_HI)
                    && (r_word[15:8] == rwcf_pkg::AZ_WRAP_LO);
    assign rng       = {1'b0, r_word[13:0]} + {7'd0, r_range_offset};
    assign az_sect   = r_word[11:8];
    assign held_sect = r_held_azimuth[11:8];
    assign neighbour = (r_current_sector == 4'd0) ? 4'd1 : (r_current_sector - 4'd1);

    always_comb begin
        n_check_started  = r_check_started;
        n_prev_azimuth   = r_prev_azimuth;
        n_prev_word      = r_prev_word;
        n_held_azimuth   = r_held_azimuth;
        n_seen_sector    = r_seen_sector;
        n_current_sector = r_current_sector;
        n_status         = rwcf_pkg::ST_OK;
        n_left           = 3'd1;
        n_bv             = 1'b0;
        for (int k = 0; k < rwcf_pkg::NUM_BYTES; k++) begin
            n_bytes[k] = 8'd0;
        end

        // check
        if (tag != rwcf_pkg::TAG_AZ && tag != rwcf_pkg::TAG_RNG
                && tag != rwcf_pkg::TAG_HGT) begin
            n_check_started = 1'b0;
            n_status        = rwcf_pkg::ST_BAD_TAG;
        end else if (!r_check_started) begin
            if (tag == rwcf_pkg::TAG_AZ) begin
                n_prev_azimuth = r_word;
            end
            n_prev_word     = r_word;
            n_check_started = 1'b1;
        end else if (tag == rwcf_pkg::TAG_AZ) begin
            n_prev_azimuth = r_word;
            if ((r_word <= pa_masked) && !az_wrap) begin
                n_check_started = 1'b0;
                n_status        = rwcf_pkg::ST_AZ_NOT_RISING;
            end else begin
                n_prev_word = r_word;
            end
        end else if (r_prev_word[15:12] == rwcf_pkg::TAG_HGT && tag != rwcf_pkg::TAG_RNG) begin
            n_check_started = 1'b0;
            n_status        = rwcf_pkg::ST_HGT_NO_RNG;
        end else begin
            n_prev_word = r_word;
        end

        // format
        if (n_status == rwcf_pkg::ST_OK) begin
            if (tag == rwcf_pkg::TAG_AZ) begin
                n_held_azimuth = r_word;
                if (az_sect != r_seen_sector) begin
                    n_seen_sector    = az_sect;
                    n_current_sector = az_sect;
                    n_bytes[0] = r_header_bytes[7:0];
                    n_bytes[1] = r_header_bytes[15:8];
                    n_bytes[2] = {r_header_bytes[23:20], az_sect};
                    n_bytes[3] = r_header_bytes[31:24];
                    n_left     = 3'd4;
                    n_bv       = 1'b1;
                end
            end else if (tag == rwcf_pkg::TAG_RNG) begin
                if (!rng[14] && (held_sect == r_current_sector || held_sect == neighbour)) begin
                    n_bytes[0] = r_held_azimuth[7:0];
                    n_bytes[1] = r_held_azimuth[15:8];
                    n_bytes[2] = rng[7:0];
                    n_bytes[3] = {2'b00, rng[13:8]};
                    n_bytes[4] = rwcf_pkg::PLOT_TAIL_4;
                    n_bytes[5] = rwcf_pkg::PLOT_TAIL_5;
                    n_left     = 3'd6;
                    n_bv       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_bytes   <= 32'd0;
            r_range_offset   <= rwcf_pkg::RANGE_OFFSET_RST;
            r_in_valid       <= 1'b0;
            r_busy           <= 1'b0;
            r_check_started  <= 1'b0;
            r_prev_azimuth   <= 16'd0;
            r_prev_word      <= 16'd0;
            r_held_azimuth   <= 16'd0;
            r_seen_sector    <= 4'd0;
            r_current_sector <= 4'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rwcf_pkg::CFG_HEADER_BYTES: r_header_bytes <= i_cfg_data;
                    rwcf_pkg::CFG_RANGE_OFFSET: r_range_offset <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_word_ch.valid && i_word_ch.ready) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end

            if (load) begin
                r_busy           <= 1'b1;
                r_check_started  <= n_check_started;
                r_prev_azimuth   <= n_prev_azimuth;
                r_prev_word      <= n_prev_word;
                r_held_azimuth   <= n_held_azimuth;
                r_seen_sector    <= n_seen_sector;
                r_current_sector <= n_current_sector;
            end else if (take && (r_left == 3'd1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_word_ch.valid && i_word_ch.ready) begin
            r_word <= i_word_ch.word_in;
        end
        if (load) begin
            r_left   <= n_left;
            r_bv     <= n_bv;
            r_status <= n_status;
            r_bytes  <= n_bytes;
        end else if (take) begin
            r_left <= r_left - 3'd1;
            for (int k = 0; k < rwcf_pkg::NUM_BYTES - 1; k++) begin
                r_bytes[k] <= r_bytes[k + 1];
            end
        end
    end

    // checks
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != 3'd0 && r_left <= 3'd6))
        else $error("result count out of range");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte_ch.valid && !o_byte_ch.byte_valid) |-> o_byte_ch.last_of_run)
        else $error("empty result not last");

    a_error_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte_ch.valid && o_byte_ch.flush_request) |-> !o_byte_ch.byte_valid)
        else $error("error result carries a byte");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !load) |=> (r_in_valid && $stable(r_word)))
        else $error("pending word lost");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// radar word checker and formatter: tagged words in, checked and formatted
// bytes out, each result compared against an in-bench prediction of the
// checker state, sector headers and plot bytes, over several register
// settings with random idling and back-pressure on both channels
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [14:0] RANGE_LIMIT  = 15'h3FFF;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          NUM_OPENING  = 25;
    localparam int          SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic              last_of_run;
        rwcf_pkg::t_status status;
        logic              flush_request;
        logic              restart_mark;
    } t_byte_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    rwcf_word_if word_ch();
    rwcf_byte_if byte_ch();

    radar_word_checker_formatter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_word_ch  (word_ch),
        .o_byte_ch  (byte_ch)
    );

    // predicted block state and registers
    logic        seq_started;
    logic [15:0] last_az;
    logic [15:0] last_word;
    logic [15:0] held_az;
    logic [3:0]  seen_sector;
    logic [3:0]  cur_sector;
    logic [31:0] header_word;
    logic [7:0]  range_offset_q;

    t_byte_result due_bytes[$];
    logic [15:0]  radar_words[$];
    logic [15:0]  sweep_az;

    int  src_idle_pct  = 19;
    int  sink_idle_pct = 19;
    int  sink_hold_req = 0;
    int  sink_hold_left = 0;
    bit  word_taken = 1'b0;
    int  cycle_count = 0;
    int  words_in = 0;
    int  bytes_out = 0;
    int  mismatch_count = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    int  header_count = 0;
    int  plot_count = 0;
    int  wrap_count = 0;

    logic [15:0] opening_words [NUM_OPENING] = '{
        16'h8000, 16'h3000, 16'h8105, 16'hC123, 16'h3FFF,
        16'h8105, 16'h8200, 16'h8100, 16'h8F10, 16'h8FFF,
        16'h8000, 16'hC000, 16'h8050, 16'h8060, 16'hC001,
        16'hC002, 16'h0000, 16'hFFFF, 16'h8100, 16'h7ABC,
        16'h3FEC, 16'h3FED, 16'hC555, 16'h3AAA, 16'h8E00
    };

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic rwcf_pkg::t_status check_sequence(input logic [15:0] w);
        logic [3:0] tag;
        logic       wrap;
        tag = w[15:12];
        if (tag != rwcf_pkg::TAG_AZ && tag != rwcf_pkg::TAG_RNG
                && tag != rwcf_pkg::TAG_HGT) begin
            seq_started = 1'b0;
            return rwcf_pkg::ST_BAD_TAG;
        end
        if (!seq_started) begin
            if (tag == rwcf_pkg::TAG_AZ)
                last_az = w;
            last_word   = w;
            seq_started = 1'b1;
            return rwcf_pkg::ST_OK;
        end
        if (tag == rwcf_pkg::TAG_AZ) begin
            last_az = last_az & rwcf_pkg::AZ_MASK;
            if (w <= last_az) begin
                wrap = (last_az[15:8] == rwcf_pkg::AZ_WRAP_HI)
                    && (w[15:8] == rwcf_pkg::AZ_WRAP_LO);
                if (!wrap) begin
                    last_az     = w;
                    seq_started = 1'b0;
                    return rwcf_pkg::ST_AZ_NOT_RISING;
                end
                wrap_count++;
            end
            last_az   = w;
            last_word = w;
        end
        if (last_word[15:12] == rwcf_pkg::TAG_HGT && tag != rwcf_pkg::TAG_RNG) begin
            seq_started = 1'b0;
            return rwcf_pkg::ST_HGT_NO_RNG;
        end
        last_word = w;
        return rwcf_pkg::ST_OK;
    endfunction

    function automatic void queue_result(input logic [7:0] b, input logic v,
                                         input logic last, input rwcf_pkg::t_status st);
        t_byte_result r;
        r.out_byte      = b;
        r.byte_valid    = v;
        r.last_of_run   = last;
        r.status        = st;
        r.flush_request = (st != rwcf_pkg::ST_OK);
        r.restart_mark  = (st == rwcf_pkg::ST_HGT_NO_RNG);
        due_bytes.push_back(r);
    endfunction

    function automatic void format_word(input logic [15:0] w);
        rwcf_pkg::t_status st;
        logic [7:0]  burst [rwcf_pkg::NUM_BYTES];
        int          n;
        int          k;
        logic [3:0]  sect;
        logic [3:0]  nbr;
        logic [14:0] rng;
        n  = 0;
        st = check_sequence(w);
        status_seen[st]++;
        if (st != rwcf_pkg::ST_OK) begin
            queue_result(8'h00, 1'b0, 1'b1, st);
            return;
        end
        if (w[15:12] == rwcf_pkg::TAG_AZ) begin
            sect   = w[11:8];
            held_az = w;
            if (sect != seen_sector) begin
                seen_sector = sect;
                cur_sector  = sect;
                burst[0] = header_word[7:0];
                burst[1] = header_word[15:8];
                burst[2] = {header_word[23:20], sect};
                burst[3] = header_word[31:24];
                n = 4;
                header_count++;
            end
        end else if (w[15:12] == rwcf_pkg::TAG_RNG) begin
            rng = {1'b0, w[13:0]} + {7'd0, range_offset_q};
            if (rng <= RANGE_LIMIT) begin
                sect = held_az[11:8];
                nbr  = (cur_sector == 4'd0) ? 4'd1 : cur_sector - 4'd1;
                if (sect == cur_sector || sect == nbr) begin
                    burst[0] = held_az[7:0];
                    burst[1] = held_az[15:8];
                    burst[2] = rng[7:0];
                    burst[3] = {1'b0, rng[14:8]};
                    burst[4] = rwcf_pkg::PLOT_TAIL_4;
                    burst[5] = rwcf_pkg::PLOT_TAIL_5;
                    n = 6;
                    plot_count++;
                end
            end
        end
        if (n == 0) begin
            queue_result(8'h00, 1'b0, 1'b1, rwcf_pkg::ST_OK);
        end else begin
            for (k = 0; k < n; k++)
                queue_result(burst[k], 1'b1, k == n - 1, rwcf_pkg::ST_OK);
        end
    endfunction

    function automatic string show(input t_byte_result r);
        return $sformatf("byte %02h valid %b last %b status %0d flush %b restart %b",
                         r.out_byte, r.byte_valid, r.last_of_run, r.status,
                         r.flush_request, r.restart_mark);
    endfunction

    // word channel driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            word_ch.valid <= 1'b0;
        end else if (!word_ch.valid || word_taken) begin
            if (radar_words.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                word_ch.valid   <= 1'b1;
                word_ch.word_in <= radar_words.pop_front();
            end else begin
                word_ch.valid   <= 1'b0;
                word_ch.word_in <= 16'($urandom_range(0, 16'hFFFF));
            end
        end
    end

    // byte channel receiver
    always @(negedge i_clk) begin
        if (sink_hold_req > 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
        end
        if (!i_rst_n) begin
            byte_ch.ready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            byte_ch.ready <= 1'b0;
            sink_hold_left--;
        end else begin
            byte_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin
        t_byte_result got;
        t_byte_result want;
        word_taken = i_rst_n && word_ch.valid && word_ch.ready;
        if (word_taken) begin
            format_word(word_ch.word_in);
            words_in++;
        end
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            got.out_byte      = byte_ch.out_byte;
            got.byte_valid    = byte_ch.byte_valid;
            got.last_of_run   = byte_ch.last_of_run;
            got.status        = byte_ch.check_status;
            got.flush_request = byte_ch.flush_request;
            got.restart_mark  = byte_ch.restart_mark;
            if (due_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_ERRORS)
                    $display("unexpected transaction %0d: %s", bytes_out, show(got));
            end else begin
                want = due_bytes.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.last_of_run !== want.last_of_run || got.status !== want.status ||
                    got.flush_request !== want.flush_request ||
                    got.restart_mark !== want.restart_mark) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS)
                        $display("mismatch at transaction %0d\n  expected %s\n  actual   %s",
                                 bytes_out, show(want), show(got));
                end
            end
            bytes_out++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_bytes.size());
            $display("[radar_word_checker_formatter_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == rwcf_pkg::CFG_HEADER_BYTES)
            header_word = val;
        else
            range_offset_q = val[7:0];
    endtask

    task automatic wait_idle();
        while (radar_words.size() != 0 || word_ch.valid || due_bytes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_word(input logic [15:0] w);
        radar_words.push_back(w);
        if (w[15:12] == rwcf_pkg::TAG_AZ)
            sweep_az = w;
    endtask

    function automatic logic [15:0] next_azimuth();
        logic [16:0] nxt;
        int          step;
        step = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 200);
        nxt  = {1'b0, sweep_az} + 17'(step);
        if (nxt > 17'h08FFF)
            nxt = {9'h080, 8'($urandom_range(0, 255))};
        return nxt[15:0];
    endfunction

    function automatic logic [15:0] range_word();
        logic [12:0] low;
        if ($urandom_range(0, 4) == 0) begin
            low = 13'(13'h0FFF - {5'd0, range_offset_q} + $urandom_range(0, 1));
            if (low > 13'h0FFF)
                low = 13'h0FFF;
        end else begin
            low = 13'($urandom_range(0, 12'hFFF));
        end
        return {rwcf_pkg::TAG_RNG, low[11:0]};
    endfunction

    task automatic fill_words(input int n_items);
        int         added;
        int         k;
        logic [3:0] tag;
        logic [11:0] body;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(0, 99) < 82) begin
                push_word(next_azimuth());
                added++;
                for (k = $urandom_range(0, 3); k > 0; k--) begin
                    if ($urandom_range(0, 2) == 0) begin
                        body = 12'($urandom_range(0, 12'hFFF));
                        push_word({rwcf_pkg::TAG_HGT, body});
                        added++;
                    end
                    push_word(range_word());
                    added++;
                end
            end else begin
                body = 12'($urandom_range(0, 12'hFFF));
                case ($urandom_range(0, 4))
                    0: begin
                        do
                            tag = 4'($urandom_range(0, 15));
                        while (tag == rwcf_pkg::TAG_AZ || tag == rwcf_pkg::TAG_RNG
                               || tag == rwcf_pkg::TAG_HGT);
                        push_word({tag, body});
                    end
                    1: push_word(16'($urandom_range(0, 16'hFFFF)));
                    2: push_word(sweep_az);
                    3: push_word({rwcf_pkg::TAG_AZ, 12'($urandom_range(0, sweep_az[11:0]))});
                    default: begin
                        push_word({rwcf_pkg::TAG_HGT, body});
                        if ($urandom_range(0, 1) == 0)
                            push_word({rwcf_pkg::TAG_HGT, ~body});
                        else
                            push_word(next_azimuth());
                        added++;
                    end
                endcase
                added++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = rwcf_pkg::CFG_HEADER_BYTES;
        i_cfg_data      = '0;
        word_ch.valid   = 1'b0;
        word_ch.word_in = '0;
        byte_ch.ready   = 1'b0;
        seq_started     = 1'b0;
        last_az         = '0;
        last_word       = '0;
        held_az         = '0;
        seen_sector     = '0;
        cur_sector      = '0;
        header_word     = '0;
        range_offset_q  = rwcf_pkg::RANGE_OFFSET_RST;
        sweep_az        = 16'h8000;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening with reset register values
        @(posedge i_clk);
        foreach (opening_words[i])
            push_word(opening_words[i]);
        wait_idle();

        // register extremes, long receiver hold-off so the block backs up
        write_reg(rwcf_pkg::CFG_HEADER_BYTES, 32'hFFFF_FFFF);
        write_reg(rwcf_pkg::CFG_RANGE_OFFSET, 32'h0000_0000);
        @(posedge i_clk);
        fill_words(62);
        @(posedge i_clk);
        sink_hold_req = 150;
        wait_idle();

        // other extremes, sender paused until everything has drained
        write_reg(rwcf_pkg::CFG_HEADER_BYTES, 32'h0000_0000);
        write_reg(rwcf_pkg::CFG_RANGE_OFFSET, 32'h0000_00FF);
        @(posedge i_clk);
        fill_words(31);
        wait_idle();
        fill_words(31);
        wait_idle();

        // random registers, no idling on either side
        write_reg(rwcf_pkg::CFG_HEADER_BYTES, $urandom);
        write_reg(rwcf_pkg::CFG_RANGE_OFFSET, $urandom_range(0, 255));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        @(posedge i_clk);
        fill_words(62);
        wait_idle();
        src_idle_pct  = 19;
        sink_idle_pct = 19;

        write_reg(rwcf_pkg::CFG_HEADER_BYTES, $urandom);
        write_reg(rwcf_pkg::CFG_RANGE_OFFSET, $urandom_range(0, 40));
        @(posedge i_clk);
        fill_words(62);
        wait_idle();

        repeat (10) @(posedge i_clk);
        $display("%0d words in, %0d results out: %0d accepted, %0d bad tag, %0d azimuth order,",
                 words_in, bytes_out, status_seen[rwcf_pkg::ST_OK],
                 status_seen[rwcf_pkg::ST_BAD_TAG],
                 status_seen[rwcf_pkg::ST_AZ_NOT_RISING]);
        $display("%0d height order, %0d headers, %0d plots, %0d sector wraps, %0d mismatches",
                 status_seen[rwcf_pkg::ST_HGT_NO_RNG], header_count, plot_count, wrap_count,
                 mismatch_count);
        if (mismatch_count == 0 && due_bytes.size() == 0) begin
            $display("[radar_word_checker_formatter_unit] OK");
        end else begin
            $display("[radar_word_checker_formatter_unit] ERROR");
        end
        $finish;
    end

endmodule
